// File: sv/asc_pkg.sv
// Shared types, constants and the per-stage divide/root step of the arc solver.
package asc_pkg;

  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 16;

  // Working widths derived from the value width.
  localparam int PW  = 2 * VALUE_BITS;      // square of a length
  localparam int MTW = 2 * VALUE_BITS + 1;  // M * (2R - M)
  localparam int NW  = 2 * VALUE_BITS + 3;  // radius numerator 4M^2 + C^2
  localparam int SW  = 2 * VALUE_BITS + 2;  // operand shift register
  localparam int DW  = VALUE_BITS + 3;      // divisor 8M
  localparam int RW  = VALUE_BITS + 4;      // partial remainder
  localparam int QW  = VALUE_BITS + 1;      // quotient or root
  localparam int NSTEPS = VALUE_BITS + 1;   // one result bit per back stage

  // Results at or below this raw value are under 1e-7 and read as zero.
  localparam logic [VALUE_BITS-1:0] TINY_MAX =
    VALUE_BITS'(((64'd1 << FRAC_BITS) - 64'd1) / 64'd10000000);
  localparam logic [VALUE_BITS-1:0] VMAX = '1;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef enum logic [1:0] {
    K_RADIUS = 2'd0,
    K_CHORD  = 2'd1,
    K_MID    = 2'd2,
    K_BAD    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DIV0    = 3'd1,
    ST_NEGROOT = 3'd2,
    ST_BADKIND = 3'd3,
    ST_SAT     = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [VALUE_BITS-1:0] mid_ordinate;
    logic [VALUE_BITS-1:0] radius;
    logic [VALUE_BITS-1:0] chord_length;
    logic                  angle_over_half;
  } in_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [2:0]            status;
  } out_t;

  // One job in flight between the front end and the back end.
  typedef struct packed {
    kind_t                 kind;
    status_t               status;
    logic                  sat;
    logic                  over;
    logic [VALUE_BITS-1:0] r;
    logic [DW-1:0]         d;
    logic [RW-1:0]         rem;
    logic [SW-1:0]         src;
    logic [QW-1:0]         q;
  } job_t;

  // One restoring-division step or one digit-by-digit square-root step.
  function automatic job_t asc_step(job_t s);
    job_t           o;
    logic [RW-1:0]  t;
    logic [RW-1:0]  sub;
    o = s;
    if (s.kind == K_RADIUS) begin
      t     = {s.rem[RW-2:0], s.src[SW-1]};
      o.src = {s.src[SW-2:0], 1'b0};
      sub   = {1'b0, s.d};
    end else begin
      t     = {s.rem[RW-3:0], s.src[SW-1:SW-2]};
      o.src = {s.src[SW-3:0], 2'b00};
      sub   = {1'b0, s.q, 2'b01};
    end
    if (t >= sub) begin
      o.rem = t - sub;
      o.q   = {s.q[QW-2:0], 1'b1};
    end else begin
      o.rem = t;
      o.q   = {s.q[QW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// File: sv/asc_front.sv
// Front end: accepts items, forms the products and sets up each divide or root job.
module asc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  asc_pkg::in_t  in_data,
  output logic          q_push,
  output asc_pkg::job_t q_data,
  input  logic          q_full
);
  import asc_pkg::*;

  logic                  a_v_r;
  kind_t                 a_kind_r;
  logic                  a_over_r;
  logic [VALUE_BITS-1:0] a_m_r;
  logic [VALUE_BITS-1:0] a_r_r;
  logic [PW-1:0]         a_mm_r;
  logic [PW-1:0]         a_cc_r;
  logic [PW-1:0]         a_rr_r;
  logic [MTW-1:0]        a_mt_r;
  logic                  b_v_r;
  job_t                  b_r;
  job_t                  b_nxt;

  logic                  a_adv;
  logic                  b_adv;
  logic [VALUE_BITS:0]   r2;
  logic                  chord_ok;
  logic [VALUE_BITS:0]   diff;
  logic [MTW-1:0]        mt_nxt;
  logic [NW-1:0]         num;
  logic [DW-1:0]         d;
  logic [NW-1:0]         arg1;
  logic [SW-1:0]         r4;

  assign b_adv   = !b_v_r || !q_full;
  assign a_adv   = !a_v_r || b_adv;
  assign in_full = !a_adv;
  assign q_push  = b_v_r && !q_full;
  assign q_data  = b_r;

  // The chord is only defined when 2R exceeds M.
  assign r2       = {in_data.radius, 1'b0};
  assign chord_ok = r2 > {1'b0, in_data.mid_ordinate};
  assign diff     = r2 - {1'b0, in_data.mid_ordinate};
  assign mt_nxt   = chord_ok ? (MTW'(in_data.mid_ordinate) * MTW'(diff)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_adv) a_v_r <= in_push;
      if (b_adv) b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      a_kind_r <= kind_t'(in_data.kind);
      a_over_r <= in_data.angle_over_half;
      a_m_r    <= in_data.mid_ordinate;
      a_r_r    <= in_data.radius;
      a_mm_r   <= in_data.mid_ordinate * in_data.mid_ordinate;
      a_cc_r   <= in_data.chord_length * in_data.chord_length;
      a_rr_r   <= in_data.radius * in_data.radius;
      a_mt_r   <= mt_nxt;
    end
    if (b_adv) b_r <= b_nxt;
  end

  assign num  = {1'b0, a_mm_r, 2'b00} + {3'b000, a_cc_r};
  assign d    = {a_m_r, 3'b000};
  assign arg1 = {a_mt_r, 2'b00};
  assign r4   = {a_rr_r, 2'b00};

  always_comb begin
    b_nxt        = '0;
    b_nxt.kind   = a_kind_r;
    b_nxt.status = ST_OK;
    b_nxt.over   = a_over_r;
    b_nxt.r      = a_r_r;
    case (a_kind_r)
      K_RADIUS: begin
        b_nxt.d = d;
        if (a_m_r == '0) begin
          b_nxt.status = ST_DIV0;
        end else if (num >= {d, {VALUE_BITS{1'b0}}}) begin
          b_nxt.sat = 1'b1;
        end else begin
          b_nxt.rem = RW'(num >> (VALUE_BITS + 1));
          b_nxt.src = {num[VALUE_BITS:0], {(SW-VALUE_BITS-1){1'b0}}};
        end
      end
      K_CHORD: begin
        if (arg1[NW-1:PW] != '0) begin
          b_nxt.sat = 1'b1;
        end else begin
          b_nxt.src = arg1[SW-1:0];
        end
      end
      K_MID: begin
        if (r4 < {2'b00, a_cc_r}) begin
          b_nxt.status = ST_NEGROOT;
        end else begin
          b_nxt.src = r4 - {2'b00, a_cc_r};
        end
      end
      default: begin
        b_nxt.status = ST_BADKIND;
      end
    endcase
  end

endmodule

// File: sv/asc_fifo.sv
// Short job queue between the front end and the back end.
module asc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  asc_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output asc_pkg::job_t dout,
  output logic          empty
);
  import asc_pkg::*;

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r;
  logic [QAW-1:0] rp_r;
  logic [QAW:0]   cnt_r;
  logic           do_push;
  logic           do_pop;

  assign full    = cnt_r == (QAW+1)'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end

endmodule

// File: sv/asc_back.sv
// Back end: shared divide/root pipeline, one result bit per stage, then the finishing stage.
module asc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  asc_pkg::job_t q_head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output asc_pkg::out_t out_data
);
  import asc_pkg::*;

  job_t                  s_r [NSTEPS];
  logic [NSTEPS-1:0]     s_v_r;
  logic                  fin_v_r;
  out_t                  fin_r;
  out_t                  fin_nxt;
  logic                  en;
  job_t                  last;
  logic [QW-1:0]         half;
  logic [VALUE_BITS:0]   sum;
  logic [VALUE_BITS:0]   val;
  logic                  sat;

  assign en        = !fin_v_r || out_pop;
  assign q_pop     = en && !q_empty;
  assign out_empty = !fin_v_r;
  assign out_data  = fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r   <= '0;
      fin_v_r <= 1'b0;
    end else if (en) begin
      s_v_r   <= {s_v_r[NSTEPS-2:0], !q_empty};
      fin_v_r <= s_v_r[NSTEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0] <= asc_step(q_head);
      for (int k = 1; k < NSTEPS; k++) begin
        s_r[k] <= asc_step(s_r[k-1]);
      end
      fin_r <= fin_nxt;
    end
  end

  assign last = s_r[NSTEPS-1];
  assign half = last.q >> 1;
  assign sum  = {1'b0, last.r} + half;

  always_comb begin
    val = '0;
    sat = last.sat;
    case (last.kind)
      K_RADIUS: if (last.status == ST_OK && !last.sat) val = last.q;
      K_CHORD:  if (!last.sat) val = last.q;
      K_MID: begin
        if (last.status == ST_OK) begin
          if (last.over) val = sum;
          else val = {1'b0, last.r - half[VALUE_BITS-1:0]};
        end
      end
      default: val = '0;
    endcase
    if (val[VALUE_BITS]) sat = 1'b1;
    if (sat) val = {1'b0, VMAX};
    if (val[VALUE_BITS-1:0] <= TINY_MAX) val = '0;
    fin_nxt.value  = val[VALUE_BITS-1:0];
    fin_nxt.status = sat ? ST_SAT : last.status;
  end

endmodule

// File: sv/arc_sagitta_chord_radius_solver.sv
// Top level of the arc radius / chord / mid-ordinate solver.
// Stages from an accepted item to its result: front products, setup, queue, one stage
// per result bit of the shared divide/root pipeline (33), finish.
// Throughput: one item per cycle while results are popped; the divide/root pipeline
// stalls as a whole only while a finished result waits on the output.
// Reset: synchronous active-low rst_n empties both the queue and the pipelines.
module arc_sagitta_chord_radius_solver (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  asc_pkg::in_t  in_data,
  output logic          out_empty,
  input  logic          out_pop,
  output asc_pkg::out_t out_data
);
  import asc_pkg::*;

  // The front end turns each transaction into a job: either a division of
  // 4M^2 + C^2 by 8M, or a square root of 4M(2R - M) or 4R^2 - C^2. Error cases and
  // input saturation are decided here; the back end saturates results that overflow.
  job_t f_job;
  logic f_push;
  logic q_full;
  job_t q_head;
  logic q_empty;
  logic q_pop;

  asc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (f_push),
    .q_data  (f_job),
    .q_full  (q_full)
  );

  // The queue lets the front end keep taking transactions while the back end
  // is held by a result that has not been popped yet.
  asc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  // The back end shares one pipeline between division and square root and
  // applies the final add or subtract, saturation and tiny-value rounding.
  asc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// File: sv/asc_checker.sv
// Port-level checker for the arc solver and its bind to the top level.
module asc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_push,
  input logic          in_full,
  input asc_pkg::in_t  in_data,
  input logic          out_empty,
  input logic          out_pop,
  input asc_pkg::out_t out_data
);
  import asc_pkg::*;

  // A reset cycle leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty)
    else $error("result dropped before pop");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> $stable(out_data))
    else $error("result changed before pop");

  // Error statuses carry a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_data.status == ST_DIV0 || out_data.status == ST_NEGROOT ||
                   out_data.status == ST_BADKIND) |-> out_data.value == '0)
    else $error("error status with nonzero value");

  // Saturation always reports the largest value.
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.status == ST_SAT |-> out_data.value == VMAX)
    else $error("saturated status without full-scale value");

endmodule

bind arc_sagitta_chord_radius_solver asc_checker u_asc_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for the arc radius, chord and mid-ordinate solver.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import asc_pkg::*;

  // The block keeps no state between transactions, so every transaction is
  // predicted on its own from the fields of the item that was pushed.
  localparam int DRAIN_CYCLES = 80;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_push = 1'b0;
  logic  in_full;
  in_t   in_data = '0;
  logic  out_empty;
  logic  out_pop = 1'b0;
  out_t  out_data;

  // Idle rates in percent for the sender and the receiver.
  int unsigned push_idle_pct = 0;
  int unsigned pop_idle_pct = 0;
  int unsigned fail_count = 0;

  // Solved values that the block has yet to deliver, oldest first.
  out_t solved_q[$];

  always #1 clk = ~clk;

  arc_sagitta_chord_radius_solver u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  // Integer square root of a 128-bit value, truncated.
  function automatic logic [63:0] isqrt128(logic [127:0] x);
    logic [63:0]  res;
    logic [63:0]  t;
    res = '0;
    for (int i = 63; i >= 0; i--) begin
      t = res | (64'd1 << i);
      if (128'(t) * 128'(t) <= x) res = t;
    end
    return res;
  endfunction

  // Solves one arc quantity exactly as the hardware must.
  function automatic out_t solve_arc(in_t it);
    out_t          o;
    logic [127:0]  m;
    logic [127:0]  r;
    logic [127:0]  c;
    logic [127:0]  num;
    logic [127:0]  q;
    logic [127:0]  r4;
    logic [127:0]  c2;
    logic [127:0]  v;
    logic          sat;
    status_t       st;
    m = 128'(it.mid_ordinate);
    r = 128'(it.radius);
    c = 128'(it.chord_length);
    v = '0;
    sat = 1'b0;
    st = ST_OK;
    case (kind_t'(it.kind))
      K_RADIUS: begin
        if (m == 0) begin
          st = ST_DIV0;
        end else begin
          num = 4 * m * m + c * c;
          q = num / (m * 8);
          if (q > 128'(VMAX)) begin
            v = 128'(VMAX);
            sat = 1'b1;
          end else begin
            v = q;
          end
        end
      end
      K_CHORD: begin
        if (2 * r > m) begin
          v = 128'(isqrt128(4 * m * (2 * r - m)));
          if (v > 128'(VMAX)) begin
            v = 128'(VMAX);
            sat = 1'b1;
          end
        end
      end
      K_MID: begin
        r4 = 4 * r * r;
        c2 = c * c;
        if (r4 < c2) begin
          st = ST_NEGROOT;
        end else begin
          q = 128'(isqrt128(r4 - c2) >> 1);
          if (!it.angle_over_half) begin
            v = r - q;
          end else begin
            v = r + q;
            if (v > 128'(VMAX)) begin
              v = 128'(VMAX);
              sat = 1'b1;
            end
          end
        end
      end
      default: st = ST_BADKIND;
    endcase
    if (sat) st = ST_SAT;
    if (v <= 128'(TINY_MAX)) v = '0;
    o.value = v[VALUE_BITS-1:0];
    o.status = st;
    return o;
  endfunction

  // Pushes one item, holding push until a transaction completes. Push is
  // only lowered when the next item chooses to idle, so it never toggles
  // twice in one time step.
  task automatic push_item(in_t it);
    while ($urandom_range(99) < push_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    solved_q = {solved_q, solve_arc(it)};
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_push <= 1'b0;
  endtask

  // Receiver: random pop at each falling edge, result checked at the rising edge.
  always @(negedge clk) begin
    if (rst_n) out_pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  always @(posedge clk) begin
    out_t exp_o;
    if (rst_n && out_pop && !out_empty) begin
      if (solved_q.size() == 0) begin
        $error("unexpected result value=%h status=%0d", out_data.value, out_data.status);
        fail_count++;
      end else begin
        exp_o = solved_q.pop_front();
        if (out_data.value !== exp_o.value) begin
          $error("value: expected %h actual %h", exp_o.value, out_data.value);
          fail_count++;
        end
        if (out_data.status !== exp_o.status) begin
          $error("status: expected %0d actual %0d", exp_o.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  function automatic in_t make_item(kind_t k, logic [31:0] m, logic [31:0] r,
                                    logic [31:0] c, logic over);
    in_t it;
    it.kind = k;
    it.mid_ordinate = m;
    it.radius = r;
    it.chord_length = c;
    it.angle_over_half = over;
    return it;
  endfunction

  // Picks a length: mostly moderate, sometimes tiny or at the extremes.
  function automatic logic [31:0] rand_len();
    case ($urandom_range(9))
      0: return $urandom_range(3);
      1: return 32'hFFFF_FFFF - $urandom_range(3);
      2: return $urandom;
      default: return $urandom_range(32'h00FF_FFFF, 32'h0000_1000);
    endcase
  endfunction

  // Builds a geometrically sensible item for the chosen kind most of the time.
  function automatic in_t rand_item();
    in_t         it;
    logic [31:0] r;
    it = make_item(kind_t'(2'($urandom_range(3))), rand_len(), rand_len(), rand_len(),
                   1'($urandom_range(1)));
    if ($urandom_range(3) != 0) begin
      r = rand_len();
      it.radius = r;
      if (it.kind == K_CHORD) it.mid_ordinate = $urandom_range(32'(r) * 2 > r ? r : 0);
      if (it.kind == K_MID) it.chord_length = $urandom_range(r > 32'h7FFF_FFFF ?
                                                             32'hFFFF_FFFF : r * 2);
    end
    return it;
  endfunction

  // Directed corners: every kind, every error case, extremes and saturation.
  task automatic test_directed();
    push_item(make_item(K_RADIUS, 32'h0001_0000, 32'h0, 32'h0002_0000, 1'b0));
    push_item(make_item(K_RADIUS, 32'h0, 32'h0, 32'h0002_0000, 1'b0));
    push_item(make_item(K_RADIUS, 32'h1, 32'h0, 32'hFFFF_FFFF, 1'b0));
    push_item(make_item(K_RADIUS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    push_item(make_item(K_RADIUS, 32'h1, 32'h0, 32'h0, 1'b0));
    push_item(make_item(K_CHORD, 32'h0001_0000, 32'h0002_0000, 32'h0, 1'b0));
    push_item(make_item(K_CHORD, 32'h0004_0000, 32'h0002_0000, 32'h0, 1'b0));
    push_item(make_item(K_CHORD, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 1'b1));
    push_item(make_item(K_CHORD, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    push_item(make_item(K_CHORD, 32'h1, 32'h1, 32'h0, 1'b0));
    push_item(make_item(K_MID, 32'h0, 32'h0002_0000, 32'h0002_0000, 1'b0));
    push_item(make_item(K_MID, 32'h0, 32'h0002_0000, 32'h0002_0000, 1'b1));
    push_item(make_item(K_MID, 32'h0, 32'h0001_0000, 32'h0003_0000, 1'b0));
    push_item(make_item(K_MID, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1));
    push_item(make_item(K_MID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    push_item(make_item(K_MID, 32'h0, 32'h0, 32'h0, 1'b0));
    push_item(make_item(K_MID, 32'h0, 32'h0001_0000, 32'h0002_0000, 1'b0));
    push_item(make_item(K_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    push_item(make_item(K_BAD, 32'h0, 32'h0, 32'h0, 1'b0));
    end_burst();
  endtask

  // Random items under one idling profile.
  task automatic test_random(int unsigned n, int unsigned snd_pct, int unsigned rcv_pct);
    push_idle_pct = snd_pct;
    pop_idle_pct = rcv_pct;
    repeat (n) push_item(rand_item());
    end_burst();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(570, 38, 67);
    test_random(570, 67, 38);
    test_random(570, 0, 0);
    // Let every result drain, then give the pipeline time for strays.
    pop_idle_pct = 0;
    while (solved_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: arc_sagitta_chord_radius_solver.f
sv/asc_pkg.sv
sv/asc_front.sv
sv/asc_fifo.sv
sv/asc_back.sv
sv/arc_sagitta_chord_radius_solver.sv
sv/asc_checker.sv
tb/tb.sv
